### rtl/core/dhfp_pkg.sv
`default_nettype none

package dhfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned RUN_W    = 3;
    localparam int unsigned FIXED_W  = 4;

    localparam logic [LEN_W-1:0]   MAX_LEN_RESET = 16'd192;
    localparam logic [BYTE_W-1:0]  SYNC_FF       = 8'hFF;
    localparam logic [BYTE_W-1:0]  SYNC_ZERO     = 8'h00;
    localparam logic [BYTE_W-1:0]  SYNC_AA       = 8'hAA;
    localparam logic [RUN_W-1:0]   FF_RUN_LEN    = 3'd5;
    localparam logic [FIXED_W-1:0] FIXED_LEN     = 4'd10;

    localparam logic KIND_LENGTH = 1'b0;
    localparam logic KIND_FIXED  = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_FIXED   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_kind;
        logic              last;
        logic              error;
    } frame_item_t;

endpackage

`default_nettype wire

### rtl/core/dhfp_if.sv
`default_nettype none

interface dhfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface dhfp_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_kind;
    logic       last;
    logic       error;

    modport source (output valid, output data_byte, output frame_kind, output last,
                    output error, input ready);
    modport sink (input valid, input data_byte, input frame_kind, input last,
                  input error, output ready);
endinterface

`default_nettype wire

### rtl/core/dhfp_front.sv
`default_nettype none

module dhfp_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dhfp_rx_if.sink                    rx,
    input  wire logic                  q_ready,
    input  wire logic                  cfg_we,
    input  wire logic [15:0]           cfg_wdata,
    output logic                       push,
    output dhfp_pkg::frame_item_t      push_item
);

    dhfp_pkg::phase_t                     phase_reg;
    dhfp_pkg::phase_t                     phase_next;
    logic [dhfp_pkg::RUN_W-1:0]           ones_run_reg;
    logic [dhfp_pkg::RUN_W-1:0]           ones_run_next;
    logic                                 prev_aa_reg;
    logic                                 prev_aa_next;
    logic [dhfp_pkg::LEN_W-1:0]           bytes_left_reg;
    logic [dhfp_pkg::LEN_W-1:0]           bytes_left_next;
    logic [dhfp_pkg::BYTE_W-1:0]          length_high_reg;
    logic [dhfp_pkg::BYTE_W-1:0]          length_high_next;
    logic [dhfp_pkg::FIXED_W-1:0]         fixed_count_reg;
    logic [dhfp_pkg::FIXED_W-1:0]         fixed_count_next;
    logic [dhfp_pkg::LEN_W-1:0]           max_len_reg;

    logic                                 accept;
    logic [dhfp_pkg::LEN_W-1:0]           len_word;
    logic [dhfp_pkg::FIXED_W-1:0]         fixed_inc;
    logic                                 len_zero;
    logic                                 len_over;
    logic                                 payload_end;
    logic                                 fixed_end;

    assign rx.ready    = q_ready;
    assign accept      = rx.valid && q_ready;
    assign len_word    = {length_high_reg, rx.rx_byte};
    assign fixed_inc   = fixed_count_reg + 1'b1;
    assign len_zero    = (len_word == '0);
    assign len_over    = (len_word > max_len_reg);
    assign payload_end = (bytes_left_reg <= dhfp_pkg::LEN_W'(1));
    assign fixed_end   = (fixed_inc >= dhfp_pkg::FIXED_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= dhfp_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= dhfp_pkg::PH_HUNT;
            ones_run_reg    <= '0;
            prev_aa_reg     <= 1'b0;
            bytes_left_reg  <= '0;
            length_high_reg <= '0;
            fixed_count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            ones_run_reg    <= ones_run_next;
            prev_aa_reg     <= prev_aa_next;
            bytes_left_reg  <= bytes_left_next;
            length_high_reg <= length_high_next;
            fixed_count_reg <= fixed_count_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        ones_run_next    = ones_run_reg;
        prev_aa_next     = prev_aa_reg;
        bytes_left_next  = bytes_left_reg;
        length_high_next = length_high_reg;
        fixed_count_next = fixed_count_reg;
        case (phase_reg)
            dhfp_pkg::PH_LEN_HI:
            begin
                length_high_next = rx.rx_byte;
                phase_next       = dhfp_pkg::PH_LEN_LO;
            end
            dhfp_pkg::PH_LEN_LO:
            begin
                if (len_zero || len_over)
                begin
                    phase_next       = dhfp_pkg::PH_HUNT;
                    ones_run_next    = '0;
                    prev_aa_next     = 1'b0;
                    bytes_left_next  = '0;
                    fixed_count_next = '0;
                end
                else
                begin
                    bytes_left_next = len_word;
                    phase_next      = dhfp_pkg::PH_PAYLOAD;
                end
            end
            dhfp_pkg::PH_PAYLOAD:
            begin
                if (payload_end)
                begin
                    phase_next       = dhfp_pkg::PH_HUNT;
                    ones_run_next    = '0;
                    prev_aa_next     = 1'b0;
                    bytes_left_next  = '0;
                    fixed_count_next = '0;
                end
                else
                begin
                    bytes_left_next = bytes_left_reg - 1'b1;
                end
            end
            dhfp_pkg::PH_FIXED:
            begin
                if (fixed_end)
                begin
                    phase_next       = dhfp_pkg::PH_HUNT;
                    ones_run_next    = '0;
                    prev_aa_next     = 1'b0;
                    bytes_left_next  = '0;
                    fixed_count_next = '0;
                end
                else
                begin
                    fixed_count_next = fixed_inc;
                end
            end
            default:
            begin
                // hunting, also for unused phase codes
                phase_next = dhfp_pkg::PH_HUNT;
                if (rx.rx_byte == dhfp_pkg::SYNC_FF)
                begin
                    if (ones_run_reg < dhfp_pkg::FF_RUN_LEN)
                    begin
                        ones_run_next = ones_run_reg + 1'b1;
                    end
                    prev_aa_next = 1'b0;
                end
                else if (rx.rx_byte == dhfp_pkg::SYNC_ZERO &&
                         ones_run_reg >= dhfp_pkg::FF_RUN_LEN)
                begin
                    ones_run_next = '0;
                    prev_aa_next  = 1'b0;
                    phase_next    = dhfp_pkg::PH_LEN_HI;
                end
                else if (rx.rx_byte == dhfp_pkg::SYNC_AA)
                begin
                    ones_run_next = '0;
                    if (prev_aa_reg)
                    begin
                        prev_aa_next     = 1'b0;
                        fixed_count_next = '0;
                        phase_next       = dhfp_pkg::PH_FIXED;
                    end
                    else
                    begin
                        prev_aa_next = 1'b1;
                    end
                end
                else
                begin
                    ones_run_next = '0;
                    prev_aa_next  = 1'b0;
                end
            end
        endcase
    end

    // item classification
    always_comb
    begin
        push                 = 1'b0;
        push_item.data_byte  = rx.rx_byte;
        push_item.frame_kind = dhfp_pkg::KIND_LENGTH;
        push_item.last       = 1'b0;
        push_item.error      = 1'b0;
        case (phase_reg)
            dhfp_pkg::PH_LEN_HI:
            begin
                push = accept;
            end
            dhfp_pkg::PH_LEN_LO:
            begin
                push           = accept;
                push_item.last = len_zero || len_over;
                push_item.error = !len_zero && len_over;
            end
            dhfp_pkg::PH_PAYLOAD:
            begin
                push           = accept;
                push_item.last = payload_end;
            end
            dhfp_pkg::PH_FIXED:
            begin
                push                 = accept;
                push_item.frame_kind = dhfp_pkg::KIND_FIXED;
                push_item.last       = fixed_end;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == dhfp_pkg::PH_HUNT) |-> !push)
        else $error("item pushed while hunting");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dhfp_pkg::PH_FIXED) |-> (fixed_count_reg < dhfp_pkg::FIXED_LEN))
        else $error("fixed frame count overran");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_item.last) |=> (phase_reg == dhfp_pkg::PH_HUNT && ones_run_reg == '0))
        else $error("frame end did not restart the hunt");

endmodule

`default_nettype wire

### rtl/core/dhfp_queue.sv
`default_nettype none

module dhfp_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire dhfp_pkg::frame_item_t push_item,
    output logic                       not_full,
    input  wire logic                  pop,
    output logic                       not_empty,
    output dhfp_pkg::frame_item_t      head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dhfp_pkg::frame_item_t  store_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> not_full)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### rtl/core/dhfp_back.sv
`default_nettype none

module dhfp_back
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire dhfp_pkg::frame_item_t q_item,
    output logic                       pop,
    dhfp_frame_if.source               frame
);

    logic                   valid_reg;
    logic                   valid_next;
    dhfp_pkg::frame_item_t  item_reg;

    assign pop        = q_valid && (!valid_reg || frame.ready);
    assign valid_next = pop || (valid_reg && !frame.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_item;
        end
    end

    assign frame.valid      = valid_reg;
    assign frame.data_byte  = item_reg.data_byte;
    assign frame.frame_kind = item_reg.frame_kind;
    assign frame.last       = item_reg.last;
    assign frame.error      = item_reg.error;

endmodule

`default_nettype wire

### rtl/core/dual_header_frame_parser.sv
// channel    dir   payload                                   handshake
// rx         in    rx_byte[7:0]                              valid/ready
// frame      out   data_byte[7:0] frame_kind last error      valid/ready
// cfg        in    cfg_wdata[15:0] = max_frame_length        cfg_we, no ready
//
// one byte accepted per cycle while the queue has room; a result passes through the queue and then the output register
// rate is set by the parser state update in the front stage
// rx.ready drops only when the queue between parser and output register is full
// rst_n clears parser state, queue pointers and output valid; max length resets to 192
`default_nettype none

module dual_header_frame_parser
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    dhfp_rx_if.sink           rx,
    dhfp_frame_if.source      frame,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata
);

    logic                   q_ready;
    logic                   q_valid;
    logic                   push;
    logic                   pop;
    dhfp_pkg::frame_item_t  push_item;
    dhfp_pkg::frame_item_t  head_item;

    dhfp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .q_ready   (q_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .push_item (push_item)
    );

    dhfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .not_full  (q_ready),
        .pop       (pop),
        .not_empty (q_valid),
        .head_item (head_item)
    );

    dhfp_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (head_item),
        .pop     (pop),
        .frame   (frame)
    );

endmodule

`default_nettype wire

### tb/tb_dual_header_frame_parser.sv
`default_nettype none

module tb_dual_header_frame_parser;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_SHOWN     = 10;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we;
    logic [dhfp_pkg::LEN_W-1:0]  cfg_wdata;

    dhfp_rx_if    rx_ch();
    dhfp_frame_if frame_ch();

    dual_header_frame_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .frame     (frame_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // parser mirror
    dhfp_pkg::phase_t              parse_state;
    logic [dhfp_pkg::RUN_W-1:0]    ff_run;
    logic                          saw_aa;
    logic [dhfp_pkg::LEN_W-1:0]    payload_left;
    logic [dhfp_pkg::BYTE_W-1:0]   len_hi_byte;
    logic [dhfp_pkg::FIXED_W-1:0]  fixed_seen;
    logic [dhfp_pkg::LEN_W-1:0]    max_len;
    dhfp_pkg::frame_item_t         frame_bytes_due[$];

    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    int results_seen;
    int cfg_writes;
    int mismatches;
    int cycle_count;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("dual_header_frame_parser regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        frame_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void rearm_hunt();
        parse_state  = dhfp_pkg::PH_HUNT;
        ff_run       = '0;
        saw_aa       = 1'b0;
        payload_left = '0;
        fixed_seen   = '0;
    endfunction

    function automatic void push_due(input logic [dhfp_pkg::BYTE_W-1:0] b, input logic kind,
                                     input logic lst, input logic err);
        dhfp_pkg::frame_item_t it;
        it.data_byte  = b;
        it.frame_kind = kind;
        it.last       = lst;
        it.error      = err;
        frame_bytes_due.push_back(it);
    endfunction

    function automatic void parse_rx_byte(input logic [dhfp_pkg::BYTE_W-1:0] b);
        logic [dhfp_pkg::LEN_W-1:0] len;
        case (parse_state)
            dhfp_pkg::PH_LEN_HI:
            begin
                len_hi_byte = b;
                parse_state = dhfp_pkg::PH_LEN_LO;
                push_due(b, dhfp_pkg::KIND_LENGTH, 1'b0, 1'b0);
            end
            dhfp_pkg::PH_LEN_LO:
            begin
                len = {len_hi_byte, b};
                if (len == '0)
                begin
                    push_due(b, dhfp_pkg::KIND_LENGTH, 1'b1, 1'b0);
                    rearm_hunt();
                end
                else if (len > max_len)
                begin
                    push_due(b, dhfp_pkg::KIND_LENGTH, 1'b1, 1'b1);
                    rearm_hunt();
                end
                else
                begin
                    payload_left = len;
                    parse_state  = dhfp_pkg::PH_PAYLOAD;
                    push_due(b, dhfp_pkg::KIND_LENGTH, 1'b0, 1'b0);
                end
            end
            dhfp_pkg::PH_PAYLOAD:
            begin
                if (payload_left <= 1)
                begin
                    push_due(b, dhfp_pkg::KIND_LENGTH, 1'b1, 1'b0);
                    rearm_hunt();
                end
                else
                begin
                    payload_left = payload_left - 1'b1;
                    push_due(b, dhfp_pkg::KIND_LENGTH, 1'b0, 1'b0);
                end
            end
            dhfp_pkg::PH_FIXED:
            begin
                fixed_seen = fixed_seen + 1'b1;
                if (fixed_seen >= dhfp_pkg::FIXED_LEN)
                begin
                    push_due(b, dhfp_pkg::KIND_FIXED, 1'b1, 1'b0);
                    rearm_hunt();
                end
                else
                begin
                    push_due(b, dhfp_pkg::KIND_FIXED, 1'b0, 1'b0);
                end
            end
            default:
            begin
                parse_state = dhfp_pkg::PH_HUNT;
                if (b == dhfp_pkg::SYNC_FF)
                begin
                    if (ff_run < dhfp_pkg::FF_RUN_LEN)
                        ff_run = ff_run + 1'b1;
                    saw_aa = 1'b0;
                end
                else if (b == dhfp_pkg::SYNC_ZERO && ff_run >= dhfp_pkg::FF_RUN_LEN)
                begin
                    ff_run      = '0;
                    saw_aa      = 1'b0;
                    parse_state = dhfp_pkg::PH_LEN_HI;
                end
                else if (b == dhfp_pkg::SYNC_AA)
                begin
                    ff_run = '0;
                    if (saw_aa)
                    begin
                        saw_aa      = 1'b0;
                        fixed_seen  = '0;
                        parse_state = dhfp_pkg::PH_FIXED;
                    end
                    else
                    begin
                        saw_aa = 1'b1;
                    end
                end
                else
                begin
                    ff_run = '0;
                    saw_aa = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic void report_mismatch(input string what,
                                            input dhfp_pkg::frame_item_t want,
                                            input dhfp_pkg::frame_item_t got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%s: expected byte %02h kind %0d last %0d error %0d, %s",
                     what, want.data_byte, want.frame_kind, want.last, want.error,
                     $sformatf("got byte %02h kind %0d last %0d error %0d",
                               got.data_byte, got.frame_kind, got.last, got.error));
    endfunction

    // outputs are stable at the falling edge; the item moves at the next rising edge
    always @(negedge clk)
    begin
        dhfp_pkg::frame_item_t got;
        dhfp_pkg::frame_item_t want;
        if (rst_n && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1)
        begin
            results_seen++;
            got.data_byte  = frame_ch.data_byte;
            got.frame_kind = frame_ch.frame_kind;
            got.last       = frame_ch.last;
            got.error      = frame_ch.error;
            if (frame_bytes_due.size() == 0)
            begin
                report_mismatch("item with nothing pending", '0, got);
            end
            else
            begin
                want = frame_bytes_due.pop_front();
                if (got.data_byte !== want.data_byte || got.frame_kind !== want.frame_kind ||
                    got.last !== want.last || got.error !== want.error)
                    report_mismatch("frame item mismatch", want, got);
            end
        end
    end

    function automatic logic [dhfp_pkg::BYTE_W-1:0] rand_byte();
        case ($urandom_range(7))
            0: return dhfp_pkg::SYNC_FF;
            1: return dhfp_pkg::SYNC_AA;
            2: return dhfp_pkg::SYNC_ZERO;
            default: return dhfp_pkg::BYTE_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [dhfp_pkg::LEN_W-1:0] pick_max_len();
        case ($urandom_range(9))
            0: return '0;
            1: return 16'hFFFF;
            2: return dhfp_pkg::MAX_LEN_RESET;
            default: return dhfp_pkg::LEN_W'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic send_byte(input logic [dhfp_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(negedge clk);
        while (rx_ch.ready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_ff_header(input int run);
        repeat (run) send_byte(dhfp_pkg::SYNC_FF);
        send_byte(dhfp_pkg::SYNC_ZERO);
    endtask

    task automatic send_length(input logic [dhfp_pkg::LEN_W-1:0] len);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_payload(input int n);
        repeat (n) send_byte(rand_byte());
    endtask

    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [dhfp_pkg::LEN_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        max_len = v;
        cfg_writes++;
    endtask

    task automatic test_length_header_cases();
        send_ff_header(7);
        send_length(16'h0000);
        send_ff_header(5);
        send_length(16'hFFFF);
    endtask

    task automatic test_fixed_frame();
        send_byte(dhfp_pkg::SYNC_AA);
        send_byte(dhfp_pkg::SYNC_AA);
        send_byte(dhfp_pkg::SYNC_AA);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFE);
        send_byte(dhfp_pkg::SYNC_AA);
        send_byte(8'h3C);
    endtask

    task automatic test_length_limits();
        write_max_len(16'h0000);
        send_ff_header(5);
        send_length(16'h0000);
        send_ff_header(5);
        send_length(16'h0001);
        write_max_len(16'hFFFF);
        send_ff_header(5);
        send_length(16'h0100);
        send_payload(256);
        // limit changed between the two length bytes
        write_max_len(dhfp_pkg::MAX_LEN_RESET);
        send_ff_header(5);
        send_byte(8'h00);
        write_max_len(16'd4);
        send_byte(8'h05);
        send_ff_header(6);
        send_length(16'd4);
        send_payload(4);
    endtask

    task automatic rand_frame();
        int                         pick;
        int                         n;
        logic [dhfp_pkg::LEN_W-1:0] len;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            send_ff_header($urandom_range(5, 7));
            case ($urandom_range(9))
                0: len = (max_len <= 64) ? max_len : dhfp_pkg::LEN_W'($urandom_range(0, 24));
                1: len = (max_len < 64) ? max_len + 1'b1
                                        : dhfp_pkg::LEN_W'($urandom_range(0, 24));
                2: len = (max_len < 16'hFFFF)
                         ? dhfp_pkg::LEN_W'($urandom_range(max_len + 1, 65535))
                         : dhfp_pkg::LEN_W'($urandom_range(0, 24));
                default: len = dhfp_pkg::LEN_W'($urandom_range(0, 24));
            endcase
            send_length(len);
            if (len != 0 && len <= max_len)
            begin
                n = len;
                if ($urandom_range(9) == 0)
                    n = $urandom_range(0, n - 1);
                send_payload(n);
            end
        end
        else if (pick < 80)
        begin
            send_byte(dhfp_pkg::SYNC_AA);
            send_byte(dhfp_pkg::SYNC_AA);
            n = dhfp_pkg::FIXED_LEN;
            if ($urandom_range(9) == 0)
                n = $urandom_range(0, dhfp_pkg::FIXED_LEN - 1);
            send_payload(n);
        end
        else if (pick < 90)
        begin
            send_payload($urandom_range(1, 6));
        end
        else
        begin
            // short ff run that must not sync
            send_ff_header($urandom_range(1, 4));
        end
    endtask

    task automatic run_traffic(input int send_pct, input int recv_pct, input int n_bytes);
        int start;
        int next_write;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_max_len(pick_max_len());
        start      = bytes_sent;
        next_write = start + 100;
        while (bytes_sent - start < n_bytes)
        begin
            rand_frame();
            if (bytes_sent >= next_write)
            begin
                write_max_len(pick_max_len());
                next_write = bytes_sent + 100;
            end
        end
    endtask

    initial
    begin
        rx_ch.valid    <= 1'b0;
        rx_ch.rx_byte  <= '0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        max_len        = dhfp_pkg::MAX_LEN_RESET;
        len_hi_byte    = '0;
        rearm_hunt();
        send_idle_pct  = 29;
        recv_idle_pct  = 81;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_length_header_cases();
        test_fixed_frame();
        test_length_limits();
        run_traffic(29, 81, 200);
        run_traffic(81, 29, 200);
        run_traffic(0, 0, 200);
        settle();

        $display("sent %0d rx bytes, checked %0d frame items under three stall mixes",
                 bytes_sent, results_seen);
        $display("max_frame_length rewritten %0d times, %0d mismatches", cfg_writes, mismatches);
        if (mismatches == 0 && frame_bytes_due.size() == 0)
        begin
            $display("dual_header_frame_parser regression: pass");
        end
        else
        begin
            $display("dual_header_frame_parser regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
